@@ rtl/dssc_pkg.sv @@
// Shared types, constants and the character table of the dual-stick sector encoder.
package dssc_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int RADIUS_W   = 15;
	localparam int R2_W       = 2 * RADIUS_W;
	localparam int CHAR_W     = 7;
	localparam int SECTOR_W   = 3;
	localparam int CHAR_COUNT = 36;
	localparam int CHAR_IDX_W = $clog2(CHAR_COUNT);

	// Register index, taken from the word address bit of paddr
	localparam logic REG_DEADZONE_RADIUS = 1'b0;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd16384;
	localparam logic [R2_W-1:0]     R2_RST     = 30'd268435456;

	typedef logic [SECTOR_W-1:0] sector_t;

	localparam sector_t SECTOR_CENTRED = 3'd0;
	localparam sector_t SECTOR_1       = 3'd1;
	localparam sector_t SECTOR_2       = 3'd2;
	localparam sector_t SECTOR_3       = 3'd3;
	localparam sector_t SECTOR_4       = 3'd4;
	localparam sector_t SECTOR_5       = 3'd5;
	localparam sector_t SECTOR_6       = 3'd6;

	typedef struct packed {
		logic [R2_W-1:0] radius_sq;
	} cfg_t;

	localparam logic [CHAR_W-1:0] CHAR_TABLE [CHAR_COUNT] = '{
		7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
		7'h67, 7'h68, 7'h69, 7'h6a, 7'h6b, 7'h6c,
		7'h6d, 7'h6e, 7'h6f, 7'h70, 7'h71, 7'h72,
		7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h79,
		7'h78, 7'h7a, 7'h30, 7'h31, 7'h32, 7'h33,
		7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39
	};

	// Character for a pair of nonzero sectors: entry (right-1)*6 + (left-1)
	function automatic logic [CHAR_W-1:0] char_lookup(sector_t rs, sector_t ls);
		logic [CHAR_IDX_W-1:0] rm;
		logic [CHAR_IDX_W-1:0] lm;
		logic [CHAR_IDX_W-1:0] idx;
		rm  = CHAR_IDX_W'(rs - SECTOR_1);
		lm  = CHAR_IDX_W'(ls - SECTOR_1);
		idx = CHAR_IDX_W'((rm << 2) + (rm << 1) + lm);
		if (idx < CHAR_IDX_W'(CHAR_COUNT)) begin
			return CHAR_TABLE[idx];
		end
		return '0;
	endfunction

endpackage

@@ rtl/dssc_if.sv @@
// Sample and result channel interfaces of the dual-stick sector encoder.
interface dssc_sample_if #(
	parameter int AXIS_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [AXIS_WIDTH-1:0] left_x;
	logic signed [AXIS_WIDTH-1:0] left_y;
	logic signed [AXIS_WIDTH-1:0] right_x;
	logic signed [AXIS_WIDTH-1:0] right_y;

	modport source (output valid, left_x, left_y, right_x, right_y, input ready);
	modport sink   (input valid, left_x, left_y, right_x, right_y, output ready);
endinterface

interface dssc_result_if;
	logic                          valid;
	logic                          ready;
	logic                          char_valid;
	logic [dssc_pkg::CHAR_W-1:0]   char_code;
	logic                          accepted;
	logic [dssc_pkg::SECTOR_W-1:0] left_sector;
	logic [dssc_pkg::SECTOR_W-1:0] right_sector;

	modport source (output valid, char_valid, char_code, accepted, left_sector, right_sector,
		input ready);
	modport sink   (input valid, char_valid, char_code, accepted, left_sector, right_sector,
		output ready);
endinterface

@@ rtl/dssc_regs.sv @@
// APB register file holding the deadzone radius and its square.
module dssc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dssc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [dssc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dssc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output dssc_pkg::cfg_t                    cfg
);

	logic [dssc_pkg::RADIUS_W-1:0] radius_q;
	logic [dssc_pkg::R2_W-1:0]     radius_sq_q;
	logic [dssc_pkg::RADIUS_W-1:0] wr_radius;
	logic                          wr_en;
	logic                          sel_radius;

	assign sel_radius = (paddr[2] == dssc_pkg::REG_DEADZONE_RADIUS);
	assign wr_en      = psel && penable && pwrite && pready && sel_radius;
	assign wr_radius  = pwdata[dssc_pkg::RADIUS_W-1:0];

	// Square once at write time so the sample path only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= dssc_pkg::RADIUS_RST;
			radius_sq_q <= dssc_pkg::R2_RST;
		end else if (wr_en) begin
			radius_q    <= wr_radius;
			radius_sq_q <= dssc_pkg::R2_W'(wr_radius) * dssc_pkg::R2_W'(wr_radius);
		end
	end

	assign pready        = 1'b1;
	assign prdata        = sel_radius ?
		{{(dssc_pkg::APB_DATA_W - dssc_pkg::RADIUS_W){1'b0}}, radius_q} : '0;
	assign cfg.radius_sq = radius_sq_q;

endmodule

@@ rtl/dssc_stick.sv @@
// One stick: squared-axis stage register and sector classification.
module dssc_stick #(
	parameter int AXIS_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic signed [AXIS_WIDTH-1:0]  x,
	input  logic signed [AXIS_WIDTH-1:0]  y,
	input  logic [dssc_pkg::R2_W-1:0]     radius_sq,
	output dssc_pkg::sector_t             sector
);

	localparam int SQ_W  = 2 * AXIS_WIDTH;
	localparam int CMP_W = (SQ_W + 1 > dssc_pkg::R2_W) ? SQ_W + 1 : dssc_pkg::R2_W;

	logic [AXIS_WIDTH-1:0] ax;
	logic [AXIS_WIDTH-1:0] ay;
	logic [SQ_W-1:0]       x2_s2;
	logic [SQ_W-1:0]       y2_s2;
	logic                  x_neg_s2;
	logic                  x_zero_s2;
	logic                  y_neg_s2;
	logic                  y_zero_s2;
	logic [SQ_W-1:0]       x2_by3;
	logic [CMP_W-1:0]      mag_sq;
	logic                  centred;
	logic                  y_lt;
	logic                  y_gt;

	// Magnitude fits unsigned even for the most negative code
	assign ax = x[AXIS_WIDTH-1] ? (~x + 1'b1) : x;
	assign ay = y[AXIS_WIDTH-1] ? (~y + 1'b1) : y;

	always_ff @(posedge clk) begin
		if (load) begin
			x2_s2     <= SQ_W'(ax) * SQ_W'(ax);
			y2_s2     <= SQ_W'(ay) * SQ_W'(ay);
			x_neg_s2  <= x[AXIS_WIDTH-1];
			x_zero_s2 <= (x == '0);
			y_neg_s2  <= y[AXIS_WIDTH-1];
			y_zero_s2 <= (y == '0);
		end
	end

	assign x2_by3  = x2_s2 + {x2_s2[SQ_W-2:0], 1'b0};
	assign mag_sq  = CMP_W'(x2_s2) + CMP_W'(y2_s2);
	assign centred = mag_sq < CMP_W'(radius_sq);
	assign y_lt    = y2_s2 < x2_by3;
	assign y_gt    = y2_s2 > x2_by3;

	// Angle runs from the negative x axis, counter-clockwise; ties go up
	always_comb begin
		if (centred) begin
			sector = dssc_pkg::SECTOR_CENTRED;
		end else if (y_neg_s2) begin
			if (x_neg_s2 && y_lt) begin
				sector = dssc_pkg::SECTOR_1;
			end else if (x_neg_s2 || x_zero_s2 || y_gt) begin
				sector = dssc_pkg::SECTOR_2;
			end else begin
				sector = dssc_pkg::SECTOR_3;
			end
		end else if (y_zero_s2) begin
			sector = x_neg_s2 ? dssc_pkg::SECTOR_1 : dssc_pkg::SECTOR_4;
		end else if (!x_neg_s2 && !x_zero_s2 && y_lt) begin
			sector = dssc_pkg::SECTOR_4;
		end else if (!x_neg_s2 || y_gt) begin
			sector = dssc_pkg::SECTOR_5;
		end else begin
			sector = dssc_pkg::SECTOR_6;
		end
	end

endmodule

@@ rtl/dual_stick_sector_char_encoder.sv @@
// Dual-stick sector character encoder: top level with sample pipeline and character logic.
// Pipeline: a request passes the input register, the squares register and the result
//   register in order; the result stays there while the result side stalls.
// Throughput: one request per cycle unless results stall; the three-stage valid/ready chain
//   fills bubbles, and the input and squares registers fill while a result waits.
// Reset (arst_n low, asynchronous): pipeline empty, previous sectors centred, deadzone
//   radius 16384. No clearing pass; the block takes requests right after reset.
module dual_stick_sector_char_encoder #(
	parameter int AXIS_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dssc_sample_if.sink                     sample,
	dssc_result_if.source                   result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dssc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dssc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dssc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	dssc_pkg::cfg_t cfg;

	// Stage valids and per-stage readiness
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic load_s1;
	logic load_s2;
	logic load_s3;

	// Input register
	logic signed [AXIS_WIDTH-1:0] left_x_s1;
	logic signed [AXIS_WIDTH-1:0] left_y_s1;
	logic signed [AXIS_WIDTH-1:0] right_x_s1;
	logic signed [AXIS_WIDTH-1:0] right_y_s1;

	// Sectors from the squares stage
	dssc_pkg::sector_t left_sec;
	dssc_pkg::sector_t right_sec;

	// Sector pair of the previous request
	dssc_pkg::sector_t prev_left_q;
	dssc_pkg::sector_t prev_right_q;

	// Character decision
	logic                        prev_pair;
	logic                        cur_pair;
	logic                        pair_changed;
	logic                        emit;
	logic [dssc_pkg::CHAR_W-1:0] code;

	// Result register
	logic                        char_valid_s3;
	logic [dssc_pkg::CHAR_W-1:0] char_code_s3;
	logic                        accepted_s3;
	dssc_pkg::sector_t           left_sector_s3;
	dssc_pkg::sector_t           right_sector_s3;

	dssc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A stage takes a new request when it is empty or its contents move on this cycle
	assign ready_s3 = !valid_s3 || result.ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;

	assign load_s1 = sample.valid && ready_s1;
	assign load_s2 = valid_s1 && ready_s2;
	assign load_s3 = valid_s2 && ready_s3;

	assign sample.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Capture the raw axes
	always_ff @(posedge clk) begin
		if (load_s1) begin
			left_x_s1  <= sample.left_x;
			left_y_s1  <= sample.left_y;
			right_x_s1 <= sample.right_x;
			right_y_s1 <= sample.right_y;
		end
	end

	// Square the axes into stage two; sectors fall out combinationally from there
	dssc_stick #(
		.AXIS_WIDTH (AXIS_WIDTH)
	) u_left (
		.clk       (clk),
		.load      (load_s2),
		.x         (left_x_s1),
		.y         (left_y_s1),
		.radius_sq (cfg.radius_sq),
		.sector    (left_sec)
	);

	dssc_stick #(
		.AXIS_WIDTH (AXIS_WIDTH)
	) u_right (
		.clk       (clk),
		.load      (load_s2),
		.x         (right_x_s1),
		.y         (right_y_s1),
		.radius_sq (cfg.radius_sq),
		.sector    (right_sec)
	);

	// Prefer the previous pair when both of its sticks were deflected, else the current one
	assign prev_pair    = (prev_left_q != dssc_pkg::SECTOR_CENTRED) &&
		(prev_right_q != dssc_pkg::SECTOR_CENTRED);
	assign cur_pair     = (left_sec != dssc_pkg::SECTOR_CENTRED) &&
		(right_sec != dssc_pkg::SECTOR_CENTRED);
	assign pair_changed = (prev_left_q != left_sec) || (prev_right_q != right_sec);
	assign emit         = (prev_pair || cur_pair) && pair_changed;
	assign code         = prev_pair ? dssc_pkg::char_lookup(prev_right_q, prev_left_q) :
		dssc_pkg::char_lookup(right_sec, left_sec);

	// Advance the sector history in request order, as each request enters the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= dssc_pkg::SECTOR_CENTRED;
			prev_right_q <= dssc_pkg::SECTOR_CENTRED;
		end else if (load_s3) begin
			prev_left_q  <= left_sec;
			prev_right_q <= right_sec;
		end
	end

	// Hold the result until taken; a character emitted with either stick released flags accept
	always_ff @(posedge clk) begin
		if (load_s3) begin
			char_valid_s3   <= emit;
			char_code_s3    <= emit ? code : '0;
			accepted_s3     <= emit && ((left_sec == dssc_pkg::SECTOR_CENTRED) ||
				(right_sec == dssc_pkg::SECTOR_CENTRED));
			left_sector_s3  <= left_sec;
			right_sector_s3 <= right_sec;
		end
	end

	assign result.valid        = valid_s3;
	assign result.char_valid   = char_valid_s3;
	assign result.char_code    = char_code_s3;
	assign result.accepted     = accepted_s3;
	assign result.left_sector  = left_sector_s3;
	assign result.right_sector = right_sector_s3;

endmodule

@@ rtl/dssc_checker.sv @@
// Port-level checker for the dual-stick sector encoder, bound to the top level.
module dssc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          char_valid,
	input logic [dssc_pkg::CHAR_W-1:0]   char_code,
	input logic                          accepted,
	input logic [dssc_pkg::SECTOR_W-1:0] left_sector,
	input logic [dssc_pkg::SECTOR_W-1:0] right_sector
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(char_code) &&
		$stable(left_sector) && $stable(right_sector))
		else $error("result changed while stalled");

	a_quiet_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !char_valid |-> char_code == '0 && !accepted)
		else $error("code or accept flag without a character");

	a_accept_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && accepted |-> char_valid &&
		(left_sector == dssc_pkg::SECTOR_CENTRED || right_sector == dssc_pkg::SECTOR_CENTRED))
		else $error("accept flagged with both sticks deflected");

	a_switch_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && char_valid && left_sector != dssc_pkg::SECTOR_CENTRED &&
		right_sector != dssc_pkg::SECTOR_CENTRED |-> !accepted)
		else $error("switch reported as accept");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> left_sector != 3'd7 && right_sector != 3'd7)
		else $error("sector out of range");

endmodule

bind dual_stick_sector_char_encoder dssc_checker u_dssc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.char_valid   (result.char_valid),
	.char_code    (result.char_code),
	.accepted     (result.accepted),
	.left_sector  (result.left_sector),
	.right_sector (result.right_sector)
);

@@ tb/testbench.sv @@
// Self-checking bench for the dual-stick sector character encoder: queued requests, APB setup.
`timescale 1ns / 1ps

module testbench;

	// Radius register sits at word 0 of the APB map
	localparam logic [dssc_pkg::APB_ADDR_W-1:0] RADIUS_ADDR =
		{dssc_pkg::REG_DEADZONE_RADIUS, 2'b00};
	// Character for entry (right-1)*6 + (left-1), first entry in the top byte
	localparam logic [8*dssc_pkg::CHAR_COUNT-1:0] GLYPHS =
		"abcdefghijklmnopqrstuvwyxz0123456789";
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 142;

	typedef struct packed {
		logic [15:0] left_x;
		logic [15:0] left_y;
		logic [15:0] right_x;
		logic [15:0] right_y;
	} stick_sample_t;

	typedef struct packed {
		logic                        char_valid;
		logic [dssc_pkg::CHAR_W-1:0] char_code;
		logic                        accepted;
		dssc_pkg::sector_t           left_sector;
		dssc_pkg::sector_t           right_sector;
	} char_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dssc_pkg::APB_ADDR_W-1:0] paddr;
	logic [dssc_pkg::APB_DATA_W-1:0] pwdata;
	logic [dssc_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	dssc_sample_if #(.AXIS_WIDTH(16)) sample_bus ();
	dssc_result_if                    result_bus ();

	dual_stick_sector_char_encoder #(.AXIS_WIDTH(16)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Requests waiting to go out, and the characters they must produce, oldest first
	stick_sample_t pending_samples [$];
	char_result_t  awaited_results [$];

	// Own copy of the block's state and its radius register
	logic [dssc_pkg::RADIUS_W-1:0] radius_model = dssc_pkg::RADIUS_RST;
	dssc_pkg::sector_t prev_left  = dssc_pkg::SECTOR_CENTRED;
	dssc_pkg::sector_t prev_right = dssc_pkg::SECTOR_CENTRED;

	int mismatches = 0;
	int n_sent = 0;
	int n_chars = 0;
	int n_released = 0;
	int n_settings = 1;
	bit [127:0] codes_seen = '0;

	// Sender burst/gap bookkeeping, owned by the driver
	int burst_left = 1;
	int gap_left = 0;

	// Receiver pattern and the long hold-off
	logic [7:0] stall_bits;
	int stall_age;
	logic hold_off = 1'b0;
	bit storm_go = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Drive every input to a known value from time zero and hold reset low, then release it
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.left_x = '0;
		sample_bus.left_y = '0;
		sample_bus.right_x = '0;
		sample_bus.right_y = '0;
		result_bus.ready = 1'b0;
		repeat (7) @(posedge clk);
		// release away from the active edge so no flop sees it mid-update
		@(negedge clk) arst_n = 1'b1;
	end

	// Sector of one stick. Works on (-x, -y) so that the negative x axis lands in
	// sector 1; rays on the axes go to the higher sector, sqrt(3) lines are tested
	// as y*y against 3*x*x.
	function automatic dssc_pkg::sector_t sector_of(logic signed [15:0] x,
		logic signed [15:0] y, logic [dssc_pkg::RADIUS_W-1:0] rad);
		longint px, py, r2, u, v, au, av, v2, u23;
		px = x;
		py = y;
		r2 = longint'(rad) * longint'(rad);
		if (px * px + py * py < r2)
			return dssc_pkg::SECTOR_CENTRED;
		u = -px;
		v = -py;
		au = (u < 0) ? -u : u;
		av = (v < 0) ? -v : v;
		v2 = av * av;
		u23 = 3 * au * au;
		if (v > 0) begin
			if (u > 0 && v2 < u23)
				return dssc_pkg::SECTOR_1;
			if (u >= 0 || v2 > u23)
				return dssc_pkg::SECTOR_2;
			return dssc_pkg::SECTOR_3;
		end
		// on the x axis: negative side is sector 1, positive side (and the origin) sector 4
		if (v == 0)
			return (u > 0) ? dssc_pkg::SECTOR_1 : dssc_pkg::SECTOR_4;
		if (u < 0 && v2 < u23)
			return dssc_pkg::SECTOR_4;
		if (u <= 0 || v2 > u23)
			return dssc_pkg::SECTOR_5;
		return dssc_pkg::SECTOR_6;
	endfunction

	// Work out the character for one accepted request and advance the sector history.
	// The previous pair wins when both of its sticks were deflected, else the current pair.
	function automatic char_result_t encode_sample(stick_sample_t s);
		char_result_t r;
		dssc_pkg::sector_t ls, rs;
		bit have;
		int idx;
		r = '0;
		have = 1'b0;
		idx = 0;
		ls = sector_of(s.left_x, s.left_y, radius_model);
		rs = sector_of(s.right_x, s.right_y, radius_model);
		if (prev_left != dssc_pkg::SECTOR_CENTRED &&
			prev_right != dssc_pkg::SECTOR_CENTRED) begin
			have = 1'b1;
			idx = (int'(prev_right) - 1) * 6 + int'(prev_left) - 1;
		end else if (ls != dssc_pkg::SECTOR_CENTRED && rs != dssc_pkg::SECTOR_CENTRED) begin
			have = 1'b1;
			idx = (int'(rs) - 1) * 6 + int'(ls) - 1;
		end
		// emit only on a change of the pair
		if (have && idx < dssc_pkg::CHAR_COUNT && (prev_left != ls || prev_right != rs)) begin
			r.char_valid = 1'b1;
			r.char_code = GLYPHS[8 * (dssc_pkg::CHAR_COUNT - 1 - idx) +: dssc_pkg::CHAR_W];
			r.accepted = (ls == dssc_pkg::SECTOR_CENTRED || rs == dssc_pkg::SECTOR_CENTRED);
		end
		r.left_sector = ls;
		r.right_sector = rs;
		prev_left = ls;
		prev_right = rs;
		return r;
	endfunction

	// One stick position: centred, on an axis, hugging a sqrt(3) line, or anywhere
	function automatic logic [31:0] stick_point(logic [dssc_pkg::RADIUS_W-1:0] rad);
		int pick, lim, a, b;
		logic [15:0] x, y, mag;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			// inside 0.7 of a nonzero radius on both axes keeps the point in the deadzone
			lim = int'(rad) * 7 / 10;
			x = 16'(int'($urandom_range(0, 2 * lim)) - lim);
			y = 16'(int'($urandom_range(0, 2 * lim)) - lim);
		end else if (pick < 27) begin
			mag = 16'($urandom);
			// sometimes land exactly on the deadzone circle
			if ($urandom_range(0, 3) == 0)
				mag = $urandom_range(0, 1) ? 16'(rad) : -16'(rad);
			if ($urandom_range(0, 1)) begin
				x = mag;
				y = '0;
			end else begin
				x = '0;
				y = mag;
			end
		end else if (pick < 40) begin
			// 56756 / 32768 is sqrt(3) to within a part in 1e5; jitter by one either way
			a = $urandom_range(0, 18917);
			b = ((a * 56756) >>> 15) + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				a = -a;
			if ($urandom_range(0, 1))
				b = -b;
			x = 16'(a);
			y = 16'(b);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
		return {x, y};
	endfunction

	// Next request of a gesture: hold the last pose, move one stick, or move both
	function automatic stick_sample_t next_sample(stick_sample_t last,
		logic [dssc_pkg::RADIUS_W-1:0] rad);
		int pick;
		stick_sample_t s;
		s = last;
		pick = $urandom_range(0, 99);
		if (pick >= 25 && pick < 35)
			{s.left_x, s.left_y} = stick_point(rad);
		else if (pick >= 35 && pick < 45)
			{s.right_x, s.right_y} = stick_point(rad);
		else if (pick >= 45) begin
			{s.left_x, s.left_y} = stick_point(rad);
			{s.right_x, s.right_y} = stick_point(rad);
		end
		return s;
	endfunction

	function automatic void queue_sample(int lx, int ly, int rx, int ry);
		stick_sample_t s;
		s.left_x = 16'(lx);
		s.left_y = 16'(ly);
		s.right_x = 16'(rx);
		s.right_y = 16'(ry);
		pending_samples.push_back(s);
	endfunction

	// Read the radius register back and compare
	task automatic check_radius(logic [dssc_pkg::RADIUS_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= RADIUS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== dssc_pkg::APB_DATA_W'(want)) begin
			$display("%0t ns: radius readback expected %0d, got %0d", $time, want, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Setup then access; the register takes the value at the access edge
	task automatic write_radius(logic [dssc_pkg::RADIUS_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RADIUS_ADDR;
		pwdata <= dssc_pkg::APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		radius_model = val;
		n_settings++;
		check_radius(val);
	endtask

	// Wait until every queued request is in and every character is out
	task automatic drain();
		int spin;
		spin = 0;
		while ((pending_samples.size() != 0 || awaited_results.size() != 0) && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
	endtask

	// Driver: offer the oldest pending request in bursts; hold it steady while refused
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
			sample_bus.left_x <= '0;
			sample_bus.left_y <= '0;
			sample_bus.right_x <= '0;
			sample_bus.right_y <= '0;
			burst_left = 1;
			gap_left = 0;
		end else if (!(sample_bus.valid && !sample_bus.ready)) begin
			// a request offered last cycle and not refused has just been taken
			if (sample_bus.valid) begin
				awaited_results.push_back(encode_sample(pending_samples.pop_front()));
				n_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				sample_bus.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample_bus.valid <= 1'b1;
				sample_bus.left_x <= pending_samples[0].left_x;
				sample_bus.left_y <= pending_samples[0].left_y;
				sample_bus.right_x <= pending_samples[0].right_x;
				sample_bus.right_y <= pending_samples[0].right_y;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					// a quarter of bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: compare each result with the oldest expectation, and drive ready
	always @(posedge clk or negedge arst_n) begin
		char_result_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_bits <= 8'hFF;
			stall_age <= 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result with nothing expected, expected none, got code %0d",
						$time, result_bus.char_code);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("char_valid", 8'(want.char_valid), 8'(result_bus.char_valid));
					check_field("char_code", 8'(want.char_code), 8'(result_bus.char_code));
					check_field("accepted", 8'(want.accepted), 8'(result_bus.accepted));
					check_field("left_sector", 8'(want.left_sector), 8'(result_bus.left_sector));
					check_field("right_sector", 8'(want.right_sector),
						8'(result_bus.right_sector));
					if (want.char_valid) begin
						n_chars++;
						codes_seen[want.char_code] = 1'b1;
						if (want.accepted)
							n_released++;
					end
				end
			end
			// reload the stall pattern each time stall_age wraps: free-flowing, sparse or heavy
			stall_age <= (stall_age + 1) % 32;
			if (stall_age == 31) begin
				case ($urandom_range(0, 2))
					0: stall_bits <= 8'hFF;
					1: stall_bits <= 8'($urandom) | 8'($urandom);
					default: stall_bits <= 8'($urandom);
				endcase
			end else begin
				stall_bits <= {stall_bits[0], stall_bits[7:1]};
			end
			result_bus.ready <= !hold_off && stall_bits[0];
		end
	end

	// Long hold-off on the result side once random traffic is flowing
	initial begin
		wait (storm_go);
		repeat (20) @(posedge clk);
		hold_off <= 1'b1;
		repeat (150) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Stimulus: directed corners per radius, then random gestures over several radii
	initial begin
		stick_sample_t last;
		logic [dssc_pkg::RADIUS_W-1:0] rad;
		@(posedge arst_n);
		check_radius(dssc_pkg::RADIUS_RST);

		// reset radius 16384
		queue_sample(0, 0, 0, 0);                          // both centred
		queue_sample(-32768, -32768, 32767, 32767);        // extremes, pair appears
		queue_sample(-20000, 0, 20000, 0);                 // negative x axis is sector 1
		queue_sample(0, -20000, 0, 20000);                 // rays on the y axis, switch
		queue_sample(20000, -2000, -20000, 2000);          // sectors 3 and 6
		queue_sample(16384, 0, 16383, 0);                  // on the circle vs just inside
		queue_sample(16383, 0, 16383, 0);                  // both released
		queue_sample(-32768, 0, 0, -32768);
		queue_sample(32767, -32768, -32768, 32767);
		queue_sample(-10000, -17320, -10000, -17321);      // either side of a sqrt(3) line
		queue_sample(10000, 17320, 10000, 17321);
		queue_sample(-10000, 17320, 10000, -17320);
		queue_sample(-10000, 17320, 10000, -17320);        // same pair, nothing emitted
		queue_sample(32767, 32767, -32768, -32768);
		queue_sample(0, 0, -20000, 0);                     // left released
		drain();

		// zero deadzone: the origin is a direction (sector 4)
		write_radius('0);
		queue_sample(0, 0, 0, 0);
		queue_sample(0, 0, 0, 0);
		queue_sample(0, 1, 1, 0);
		drain();

		// widest deadzone
		write_radius(15'd32767);
		queue_sample(32767, 0, -32768, 0);
		queue_sample(32766, 0, 0, -32767);
		queue_sample(23170, 23170, -23170, 23170);
		queue_sample(0, 0, 0, 0);
		drain();

		last = '0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: rad = dssc_pkg::RADIUS_RST;
				1: rad = 15'd1;
				2: rad = 15'd32767;
				3: rad = '0;
				4: rad = 15'($urandom_range(1, 3000));
				default: rad = 15'($urandom);
			endcase
			write_radius(rad);
			storm_go = 1'b1;
			for (int k = 0; k < PHASE_SAMPLES; k++) begin
				last = next_sample(last, rad);
				pending_samples.push_back(last);
			end
			drain();
		end

		// let any stray result show itself
		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t ns: %0d results expected, got none", $time, awaited_results.size());
			mismatches++;
		end
		$display("Run: %0d samples over %0d deadzone settings, incl. zero and full scale.",
			n_sent, n_settings);
		$display("Characters: %0d emitted (%0d on release), %0d of %0d table entries seen.",
			n_chars, n_released, $countones(codes_seen), dssc_pkg::CHAR_COUNT);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
